// File: rtl/multilevel_fifo_priority_queue_unit_defines.svh
// assertion macros for the multilevel fifo priority queue unit
`ifndef MULTILEVEL_FIFO_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MULTILEVEL_FIFO_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// generic implication checked on every clock edge out of reset
`define MFPQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication qualified by a valid result beat
`define MFPQ_ASSERT_BEAT(label, clk, rstn, vld, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) ((vld) && (ante)) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/mfpq_pkg.sv
// shared types and constants for the multilevel fifo priority queue
`timescale 1ns / 1ps

package mfpq_pkg;

    // port field widths
    localparam int CMD_W     = 2;
    localparam int ID_PORT_W = 8;
    localparam int PRI_W     = 6;
    localparam int STAT_W    = 2;
    localparam int TOTAL_W   = 9;

    // parameter defaults
    localparam int LEVELS_DEF      = 16;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPRI = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_ENQ,
        OP_BADPRI,
        OP_DEQ,
        OP_PEEK
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [PRI_W-1:0]     level;
        logic [ID_PORT_W-1:0] id;
    } entry_t;

endpackage

// File: rtl/mfpq_front.sv
// front end: accepts command beats and classifies them into operations
`timescale 1ns / 1ps

module mfpq_front #(
    parameter int LEVELS = mfpq_pkg::LEVELS_DEF
) (
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mfpq_pkg::CMD_W-1:0]     s_command,
    input  logic [mfpq_pkg::ID_PORT_W-1:0] s_item_id,
    input  logic [mfpq_pkg::PRI_W-1:0]     s_priority_req,
    output logic                           q_valid,
    input  logic                           q_ready,
    output mfpq_pkg::entry_t               q_entry
);

    localparam int CMP_W = mfpq_pkg::PRI_W + 1;

    logic bad_pri;

    // priority bound check
    assign bad_pri = ({1'b0, s_priority_req} >= CMP_W'(LEVELS));

    // command decode, unused command acts as a peek
    always_comb begin
        q_entry.level = s_priority_req;
        q_entry.id    = s_item_id;
        case (s_command)
            mfpq_pkg::CMD_ENQUEUE: begin
                q_entry.op = bad_pri ? mfpq_pkg::OP_BADPRI : mfpq_pkg::OP_ENQ;
            end
            mfpq_pkg::CMD_DEQUEUE: begin
                q_entry.op = mfpq_pkg::OP_DEQ;
            end
            mfpq_pkg::CMD_PEEK: begin
                q_entry.op = mfpq_pkg::OP_PEEK;
            end
            default: begin
                q_entry.op = mfpq_pkg::OP_PEEK;
            end
        endcase
    end

    assign q_valid = s_valid;
    assign s_ready = q_ready;

endmodule

// File: rtl/mfpq_queue.sv
// two-entry operation queue between front and back
`timescale 1ns / 1ps

module mfpq_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mfpq_pkg::entry_t in_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output mfpq_pkg::entry_t out_entry
);

    localparam int DEPTH = 2;

    mfpq_pkg::entry_t buf_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg != 2'(DEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_entry = buf_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// File: rtl/mfpq_back.sv
// back end: level state, slot memory and result register
`timescale 1ns / 1ps

module mfpq_back #(
    parameter int LEVELS      = mfpq_pkg::LEVELS_DEF,
    parameter int LEVEL_DEPTH = mfpq_pkg::LEVEL_DEPTH_DEF,
    parameter int ID_WIDTH    = mfpq_pkg::ID_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  mfpq_pkg::entry_t               q_entry,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mfpq_pkg::STAT_W-1:0]    m_status,
    output logic [mfpq_pkg::ID_PORT_W-1:0] m_out_id,
    output logic [mfpq_pkg::PRI_W-1:0]     m_out_level,
    output logic [mfpq_pkg::TOTAL_W-1:0]   m_total_items
);

    localparam int LW    = $clog2(LEVELS);
    localparam int PW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int SUMW  = CW + 1;
    localparam int AW    = LW + PW;
    localparam int SLOTS = 1 << AW;
    localparam int SW    = (ID_WIDTH < mfpq_pkg::ID_PORT_W) ? ID_WIDTH : mfpq_pkg::ID_PORT_W;
    localparam int TW    = $clog2(LEVELS * LEVEL_DEPTH + 1);
    localparam int OIW   = mfpq_pkg::ID_PORT_W;
    localparam int OLW   = mfpq_pkg::PRI_W;
    localparam int OTW   = mfpq_pkg::TOTAL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEVEL,
        S_SLOT
    } state_t;

    typedef struct packed {
        logic [PW-1:0] head;
        logic [CW-1:0] count;
    } lvl_state_t;

    // control and payload registers
    state_t                   state_reg;
    mfpq_pkg::op_t            op_reg;
    logic [LW-1:0]            lvl_reg;
    logic [SW-1:0]            id_reg;
    logic [LEVELS-1:0]        nonempty_reg;
    logic [TW-1:0]            total_reg;
    logic                     m_valid_reg;
    logic [mfpq_pkg::STAT_W-1:0] m_status_reg;
    logic [OIW-1:0]           m_out_id_reg;
    logic [OLW-1:0]           m_out_level_reg;
    logic [OTW-1:0]           m_total_reg;

    // level state memory with per-level valid bits
    lvl_state_t               lvl_mem [LEVELS];
    logic [LEVELS-1:0]        lvl_vld_reg;
    lvl_state_t               lvl_rd_reg;
    logic                     lvl_rd_vld_reg;

    // slot memory
    logic [SW-1:0]            slot_mem [SLOTS];
    logic [SW-1:0]            slot_rd_reg;

    logic                     out_free;
    logic                     res_load;
    logic [LW-1:0]            first_lvl;
    logic                     q_is_enq;
    logic                     q_fail;
    logic [LW-1:0]            q_lvl;
    lvl_state_t               lvl_cur;
    logic                     lvl_full;
    logic [SUMW-1:0]          tail_sum;
    logic [PW-1:0]            tail;
    logic [PW-1:0]            head_inc;
    logic                     enq_commit;
    logic                     deq_commit;
    logic                     lvl_re;
    logic                     lvl_we;
    lvl_state_t               lvl_wdata;
    logic                     slot_re;

    assign out_free = !m_valid_reg || m_ready;

    // lowest-numbered non-empty level
    always_comb begin
        first_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (nonempty_reg[i]) begin
                first_lvl = LW'(i);
            end
        end
    end

    // dispatch of the operation at the queue head
    assign q_is_enq = (q_entry.op == mfpq_pkg::OP_ENQ);
    assign q_fail   = (q_entry.op == mfpq_pkg::OP_BADPRI) ||
                      (!q_is_enq && (nonempty_reg == '0));
    assign q_lvl    = q_is_enq ? LW'(q_entry.level) : first_lvl;
    assign q_ready  = (state_reg == S_IDLE) && q_valid && (!q_fail || out_free);
    assign lvl_re   = q_ready && !q_fail;

    // result register load
    assign res_load = ((state_reg == S_IDLE) && q_ready && q_fail) ||
                      ((state_reg == S_LEVEL) && (op_reg == mfpq_pkg::OP_ENQ) && out_free) ||
                      ((state_reg == S_SLOT) && out_free);

    // level state arithmetic
    assign lvl_cur  = lvl_rd_vld_reg ? lvl_rd_reg : '0;
    assign lvl_full = (lvl_cur.count == CW'(LEVEL_DEPTH));
    assign tail_sum = SUMW'(lvl_cur.head) + SUMW'(lvl_cur.count);
    assign tail     = (tail_sum >= SUMW'(LEVEL_DEPTH)) ?
                      PW'(tail_sum - SUMW'(LEVEL_DEPTH)) : PW'(tail_sum);
    assign head_inc = (lvl_cur.head == PW'(LEVEL_DEPTH - 1)) ?
                      '0 : lvl_cur.head + PW'(1);

    // commits of the level state
    assign enq_commit = (state_reg == S_LEVEL) && (op_reg == mfpq_pkg::OP_ENQ) &&
                        out_free && !lvl_full;
    assign deq_commit = (state_reg == S_LEVEL) && (op_reg == mfpq_pkg::OP_DEQ);
    assign lvl_we     = enq_commit || deq_commit;
    assign slot_re    = (state_reg == S_LEVEL) && (op_reg != mfpq_pkg::OP_ENQ);

    always_comb begin
        if (enq_commit) begin
            lvl_wdata.head  = lvl_cur.head;
            lvl_wdata.count = lvl_cur.count + CW'(1);
        end else begin
            lvl_wdata.head  = head_inc;
            lvl_wdata.count = lvl_cur.count - CW'(1);
        end
    end

    // level state memory port
    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[lvl_reg] <= lvl_wdata;
        end
        if (lvl_re) begin
            lvl_rd_reg <= lvl_mem[q_lvl];
        end
    end

    // per-level valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_vld_reg    <= '0;
            lvl_rd_vld_reg <= 1'b0;
        end else begin
            if (lvl_we) begin
                lvl_vld_reg[lvl_reg] <= 1'b1;
            end
            if (lvl_re) begin
                lvl_rd_vld_reg <= lvl_vld_reg[q_lvl];
            end
        end
    end

    // slot memory port
    always_ff @(posedge aclk) begin
        if (enq_commit) begin
            slot_mem[{lvl_reg, tail}] <= id_reg;
        end
        if (slot_re) begin
            slot_rd_reg <= slot_mem[{lvl_reg, lvl_cur.head}];
        end
    end

    // sequencer, counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nonempty_reg <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_ready) begin
                        if (q_fail) begin
                            m_status_reg    <= q_is_enq ? mfpq_pkg::ST_OK :
                                               (q_entry.op == mfpq_pkg::OP_BADPRI) ?
                                               mfpq_pkg::ST_BADPRI : mfpq_pkg::ST_EMPTY;
                            m_out_id_reg    <= '0;
                            m_out_level_reg <= '0;
                            m_total_reg     <= OTW'(total_reg);
                        end else begin
                            op_reg    <= q_entry.op;
                            lvl_reg   <= q_lvl;
                            id_reg    <= SW'(q_entry.id);
                            state_reg <= S_LEVEL;
                        end
                    end
                end
                S_LEVEL: begin
                    if (op_reg == mfpq_pkg::OP_ENQ) begin
                        if (out_free) begin
                            m_out_id_reg <= '0;
                            state_reg    <= S_IDLE;
                            if (lvl_full) begin
                                m_status_reg    <= mfpq_pkg::ST_FULL;
                                m_out_level_reg <= '0;
                                m_total_reg     <= OTW'(total_reg);
                            end else begin
                                m_status_reg          <= mfpq_pkg::ST_OK;
                                m_out_level_reg       <= OLW'(lvl_reg);
                                m_total_reg           <= OTW'(total_reg + TW'(1));
                                total_reg             <= total_reg + TW'(1);
                                nonempty_reg[lvl_reg] <= 1'b1;
                            end
                        end
                    end else begin
                        // dequeue retires the head now, the slot data follows
                        if (deq_commit) begin
                            total_reg <= total_reg - TW'(1);
                            if (lvl_cur.count == CW'(1)) begin
                                nonempty_reg[lvl_reg] <= 1'b0;
                            end
                        end
                        state_reg <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    if (out_free) begin
                        m_status_reg    <= mfpq_pkg::ST_OK;
                        m_out_id_reg    <= OIW'(slot_rd_reg);
                        m_out_level_reg <= OLW'(lvl_reg);
                        m_total_reg     <= OTW'(total_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_id      = m_out_id_reg;
    assign m_out_level   = m_out_level_reg;
    assign m_total_items = m_total_reg;

endmodule

// File: rtl/multilevel_fifo_priority_queue_unit.sv
// top level of the multilevel fifo priority queue unit
`timescale 1ns / 1ps
`include "multilevel_fifo_priority_queue_unit_defines.svh"

// Ready queue with one FIFO per priority level, level 0 most urgent. Every
// command beat (enqueue, dequeue, peek) returns exactly one result beat with
// a status and the item count after the command. Commands pass a two-entry
// queue and are then executed one at a time: a rejected command (bad priority,
// empty queue) is answered from the idle state, an enqueue goes through a level
// state memory read, then a slot memory and level state write, and a dequeue or
// peek through a level state read, a slot memory read, then the result. Those
// registered memory reads and the pass through the command queue set the command time.
// Per-level state is cleared at reset through valid bits; no clearing pass.
module multilevel_fifo_priority_queue_unit #(
    parameter int LEVELS      = mfpq_pkg::LEVELS_DEF,
    parameter int LEVEL_DEPTH = mfpq_pkg::LEVEL_DEPTH_DEF,
    parameter int ID_WIDTH    = mfpq_pkg::ID_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mfpq_pkg::CMD_W-1:0]     s_command,
    input  logic [mfpq_pkg::ID_PORT_W-1:0] s_item_id,
    input  logic [mfpq_pkg::PRI_W-1:0]     s_priority_req,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mfpq_pkg::STAT_W-1:0]    m_status,
    output logic [mfpq_pkg::ID_PORT_W-1:0] m_out_id,
    output logic [mfpq_pkg::PRI_W-1:0]     m_out_level,
    output logic [mfpq_pkg::TOTAL_W-1:0]   m_total_items
);

    localparam int LVL_CMP_W = mfpq_pkg::PRI_W + 1;

    logic             fq_valid;
    logic             fq_ready;
    mfpq_pkg::entry_t fq_entry;
    logic             qb_valid;
    logic             qb_ready;
    mfpq_pkg::entry_t qb_entry;

    // command classification
    mfpq_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_item_id      (s_item_id),
        .s_priority_req (s_priority_req),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_entry        (fq_entry)
    );

    // decoupling queue
    mfpq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_entry (qb_entry)
    );

    // execution
    mfpq_back #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_entry       (qb_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_id      (m_out_id),
        .m_out_level   (m_out_level),
        .m_total_items (m_total_items)
    );

    // error results carry no id and no level
    `MFPQ_ASSERT_BEAT(a_err_zero, aclk, aresetn, m_valid, m_status != mfpq_pkg::ST_OK, (m_out_id == '0) && (m_out_level == '0), "error beat with nonzero id or level")

    // an empty report means nothing is held
    `MFPQ_ASSERT_BEAT(a_empty_total, aclk, aresetn, m_valid, m_status == mfpq_pkg::ST_EMPTY, m_total_items == '0, "empty beat with nonzero total")

    // a good result names an existing level
    `MFPQ_ASSERT_BEAT(a_ok_level, aclk, aresetn, m_valid, m_status == mfpq_pkg::ST_OK, LVL_CMP_W'(m_out_level) < LVL_CMP_W'(LEVELS), "ok beat from a level out of range")

    // the back end never takes from an empty command queue
    `MFPQ_ASSERT_IMPL(a_pop_valid, aclk, aresetn, qb_ready, qb_valid, "command taken from empty queue")

endmodule

// File: dv/multilevel_fifo_priority_queue_checker.sv
// checker for the multilevel fifo priority queue: predicts results and compares them
`timescale 1ns / 1ps

module multilevel_fifo_priority_queue_checker #(
    parameter int LEVELS      = mfpq_pkg::LEVELS_DEF,
    parameter int LEVEL_DEPTH = mfpq_pkg::LEVEL_DEPTH_DEF,
    parameter int ID_WIDTH    = mfpq_pkg::ID_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [mfpq_pkg::CMD_W-1:0]     s_command,
    input  logic [mfpq_pkg::ID_PORT_W-1:0] s_item_id,
    input  logic [mfpq_pkg::PRI_W-1:0]     s_priority_req,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [mfpq_pkg::STAT_W-1:0]    m_status,
    input  logic [mfpq_pkg::ID_PORT_W-1:0] m_out_id,
    input  logic [mfpq_pkg::PRI_W-1:0]     m_out_level,
    input  logic [mfpq_pkg::TOTAL_W-1:0]   m_total_items,
    output int                             fail_count,
    output int                             pending
);

    localparam int IDW = mfpq_pkg::ID_PORT_W;
    localparam int PRW = mfpq_pkg::PRI_W;
    localparam int TTW = mfpq_pkg::TOTAL_W;
    localparam logic [IDW-1:0] ID_MASK = IDW'((64'd1 << ID_WIDTH) - 1);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [mfpq_pkg::STAT_W-1:0] status;
        logic [IDW-1:0]              out_id;
        logic [PRW-1:0]              out_level;
        logic [TTW-1:0]              total;
    } queue_result_t;

    // shadow copy of the per-level fifos
    logic [IDW-1:0]       slot_mem [LEVELS][LEVEL_DEPTH];
    int                   head_idx [LEVELS];
    int                   fill_cnt [LEVELS];
    int                   held_total;

    queue_result_t        awaited_results [$];
    int                   mismatches;

    initial begin
        mismatches = 0;
        held_total = 0;
        for (int l = 0; l < LEVELS; l++) begin
            head_idx[l] = 0;
            fill_cnt[l] = 0;
        end
    end

    // apply one command to the shadow queue and return its result
    function automatic queue_result_t execute_command(
        input logic [mfpq_pkg::CMD_W-1:0] cmd,
        input logic [IDW-1:0]             id,
        input logic [PRW-1:0]             pri
    );
        queue_result_t res;
        int            lvl;
        int            tail;
        int            l;
        res = '0;
        if (cmd == mfpq_pkg::CMD_ENQUEUE) begin
            if (pri >= LEVELS) begin
                res.status = mfpq_pkg::ST_BADPRI;
            end else if (fill_cnt[pri] >= LEVEL_DEPTH) begin
                res.status = mfpq_pkg::ST_FULL;
            end else begin
                tail = (head_idx[pri] + fill_cnt[pri]) % LEVEL_DEPTH;
                slot_mem[pri][tail] = id & ID_MASK;
                fill_cnt[pri]++;
                held_total++;
                res.status    = mfpq_pkg::ST_OK;
                res.out_level = pri;
            end
        end else begin
            // dequeue, peek and the unused code all look at the most urgent head
            lvl = -1;
            for (l = LEVELS - 1; l >= 0; l--) begin
                if (fill_cnt[l] > 0) lvl = l;
            end
            if (lvl < 0) begin
                res.status = mfpq_pkg::ST_EMPTY;
            end else begin
                res.status    = mfpq_pkg::ST_OK;
                res.out_id    = slot_mem[lvl][head_idx[lvl]];
                res.out_level = PRW'(lvl);
                if (cmd == mfpq_pkg::CMD_DEQUEUE) begin
                    head_idx[lvl] = (head_idx[lvl] + 1) % LEVEL_DEPTH;
                    fill_cnt[lvl]--;
                    held_total--;
                end
            end
        end
        res.total = TTW'(held_total);
        return res;
    endfunction

    // watch both channels at the rising edge
    always @(posedge aclk) begin : monitor
        queue_result_t want;
        queue_result_t got;
        if (!aresetn) begin
            for (int l = 0; l < LEVELS; l++) begin
                head_idx[l] = 0;
                fill_cnt[l] = 0;
            end
            held_total = 0;
            awaited_results.delete();
        end else begin
            // command beat: predict its result
            if (s_valid && s_ready) begin
                awaited_results.push_back(execute_command(s_command, s_item_id,
                                                          s_priority_req));
            end
            // result beat: compare against the oldest prediction
            if (m_valid && m_ready) begin
                got.status    = m_status;
                got.out_id    = m_out_id;
                got.out_level = m_out_level;
                got.total     = m_total_items;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result beat: status %0d id %0d level %0d total %0d",
                                 $time, got.status, got.out_id, got.out_level, got.total);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (want !== got) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $write("%0t: result mismatch: expected status %0d id %0d ",
                                   $time, want.status, want.out_id);
                            $write("level %0d total %0d, ", want.out_level, want.total);
                            $display("got status %0d id %0d level %0d total %0d",
                                     got.status, got.out_id, got.out_level, got.total);
                        end
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= awaited_results.size();
    end

endmodule

// File: dv/tb_multilevel_fifo_priority_queue_unit.sv
// testbench top for the multilevel fifo priority queue unit: stimulus and verdict
`timescale 1ns / 1ps

module tb_multilevel_fifo_priority_queue_unit;

    localparam int LEVELS      = mfpq_pkg::LEVELS_DEF;
    localparam int LEVEL_DEPTH = mfpq_pkg::LEVEL_DEPTH_DEF;
    localparam int ID_WIDTH    = mfpq_pkg::ID_WIDTH_DEF;

    localparam int CW  = mfpq_pkg::CMD_W;
    localparam int IDW = mfpq_pkg::ID_PORT_W;
    localparam int PRW = mfpq_pkg::PRI_W;

    // the fourth command code behaves as a peek
    localparam logic [CW-1:0] CMD_UNUSED = 2'd3;

    localparam int HALF_PERIOD  = 2;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE       = 20;
    localparam int MIX_BEATS    = 110;
    localparam int FILL_BEATS   = 300;
    localparam int DRAIN_BEATS  = 130;
    localparam int CALM_BEATS   = 80;

    typedef enum int {
        MODE_MIX,
        MODE_FILL,
        MODE_DRAIN
    } traffic_mode_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [CW-1:0]                     s_command;
    logic [IDW-1:0]                    s_item_id;
    logic [PRW-1:0]                    s_priority_req;
    logic                              m_valid;
    logic                              m_ready;
    logic [mfpq_pkg::STAT_W-1:0]       m_status;
    logic [IDW-1:0]                    m_out_id;
    logic [PRW-1:0]                    m_out_level;
    logic [mfpq_pkg::TOTAL_W-1:0]      m_total_items;

    int fail_count;
    int pending;
    bit calm;
    bit long_hold_req;
    int sweep_level;

    multilevel_fifo_priority_queue_unit #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_item_id      (s_item_id),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_id       (m_out_id),
        .m_out_level    (m_out_level),
        .m_total_items  (m_total_items)
    );

    multilevel_fifo_priority_queue_checker #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_item_id      (s_item_id),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_id       (m_out_id),
        .m_out_level    (m_out_level),
        .m_total_items  (m_total_items),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall bursts, one long hold on request, none when calm
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                long_hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // offer one command beat, with an occasional idle burst ahead of it
    task automatic send_beat(
        input logic [CW-1:0]  cmd,
        input logic [IDW-1:0] id,
        input logic [PRW-1:0] pri
    );
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? int'($urandom_range(1, 19)) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_command      = cmd;
        s_item_id      = id;
        s_priority_req = pri;
        do @(posedge aclk); while (!s_ready);
    endtask

    // random command beat shaped by the traffic mode
    task automatic random_beat(input traffic_mode_t mode);
        int            roll;
        logic [CW-1:0] cmd;
        logic [PRW-1:0] pri;
        roll = int'($urandom_range(0, 99));
        pri  = PRW'($urandom_range(0, LEVELS - 1));
        case (mode)
            MODE_FILL: begin
                // sweep the levels so that every one of them fills up
                if ($urandom_range(0, 9) < 7) begin
                    pri = PRW'(sweep_level);
                    sweep_level = (sweep_level + 1) % LEVELS;
                end
                cmd = (roll < 97) ? mfpq_pkg::CMD_ENQUEUE : mfpq_pkg::CMD_DEQUEUE;
            end
            MODE_DRAIN: begin
                cmd = (roll < 15) ? mfpq_pkg::CMD_ENQUEUE :
                      (roll < 85) ? mfpq_pkg::CMD_DEQUEUE : mfpq_pkg::CMD_PEEK;
            end
            default: begin
                cmd = (roll < 45) ? mfpq_pkg::CMD_ENQUEUE :
                      (roll < 75) ? mfpq_pkg::CMD_DEQUEUE : mfpq_pkg::CMD_PEEK;
            end
        endcase
        // noise: out-of-range priority or the unused command code
        roll = int'($urandom_range(0, 99));
        if (roll < 4) begin
            pri = PRW'($urandom_range(LEVELS, 63));
            cmd = mfpq_pkg::CMD_ENQUEUE;
        end else if (roll < 7) begin
            cmd = CMD_UNUSED;
        end
        send_beat(cmd, IDW'($urandom_range(0, 255)), pri);
    endtask

    // hold the command side until every predicted result has arrived or the drain limit is reached
    task automatic wait_drained;
        int cycles;
        cycles = 0;
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0 && cycles < DRAIN_LIMIT) begin
            @(negedge aclk);
            cycles++;
        end
    endtask

    // stimulus and verdict
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_command      = mfpq_pkg::CMD_ENQUEUE;
        s_item_id      = '0;
        s_priority_req = '0;
        calm           = 1'b0;
        long_hold_req  = 1'b0;
        sweep_level    = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty queue on every read command
        send_beat(mfpq_pkg::CMD_DEQUEUE, 8'h00, 6'd0);
        send_beat(mfpq_pkg::CMD_PEEK, 8'hFF, 6'd63);
        send_beat(CMD_UNUSED, 8'h5A, 6'd21);
        // bad priority at the boundary and at the top
        send_beat(mfpq_pkg::CMD_ENQUEUE, 8'hFF, 6'(LEVELS));
        send_beat(mfpq_pkg::CMD_ENQUEUE, 8'hAA, 6'd63);
        // extreme levels and ids, then priority order on the way out
        send_beat(mfpq_pkg::CMD_ENQUEUE, 8'hFF, 6'(LEVELS - 1));
        send_beat(mfpq_pkg::CMD_ENQUEUE, 8'h00, 6'd0);
        send_beat(mfpq_pkg::CMD_ENQUEUE, 8'h55, 6'd0);
        send_beat(mfpq_pkg::CMD_PEEK, 8'h00, 6'd0);
        send_beat(CMD_UNUSED, 8'hFF, 6'd63);
        send_beat(mfpq_pkg::CMD_DEQUEUE, 8'h00, 6'd0);
        send_beat(mfpq_pkg::CMD_DEQUEUE, 8'hFF, 6'd0);
        send_beat(mfpq_pkg::CMD_DEQUEUE, 8'h00, 6'd63);
        send_beat(mfpq_pkg::CMD_DEQUEUE, 8'h00, 6'd0);

        // mixed traffic around an often empty queue
        for (int i = 0; i < MIX_BEATS; i++) random_beat(MODE_MIX);

        // pause until all results are back
        wait_drained();

        // fill every level while the result side holds off for a long stretch
        long_hold_req = 1'b1;
        for (int i = 0; i < FILL_BEATS; i++) random_beat(MODE_FILL);

        // drain, with no idling in the closing stretch
        for (int i = 0; i < DRAIN_BEATS; i++) begin
            if (i == DRAIN_BEATS - CALM_BEATS) calm = 1'b1;
            random_beat(MODE_DRAIN);
        end

        wait_drained();
        repeat (SETTLE) @(negedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
